### rtl/hfj_pkg.sv
// ============================================================================
// hfj_pkg: shared definitions for the Halton frame jitter unit
// Widths, codes, fixed constants and the sequencer state type.
// ============================================================================
package hfj_pkg;

  // Operation codes carried by an input transaction
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_RESET   = 1'b1;

  // Configuration port geometry
  localparam int          CFG_ADDR_W      = 3;
  localparam int          CFG_DATA_W      = 32;
  localparam logic        REG_STRENGTH    = 1'b0;    // register select, paddr[2]
  localparam logic [15:0] STRENGTH_RESET  = 16'd256; // 1.0 in Q8.8

  // Radical inverse constants
  localparam int          TERNARY_DIGITS  = 21;
  localparam int          FRAC_BITS       = 24;
  localparam int          REV_W           = 34;                // holds 3^21 - 1
  localparam logic [33:0] TERN_SPAN       = 34'd10460353203;   // 3^21
  localparam logic [31:0] RECIP3          = 32'hAAAAAAAB;      // ceil(2^33 / 3)
  localparam logic [23:0] HALF_Q24        = 24'h800000;

  // Step counter covers the longer of the digit and quotient phases
  localparam int          CNT_W           = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_DIVIDE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_DONE
  } hfj_state_t;

endpackage

### rtl/hfj_if.sv
// ============================================================================
// hfj_if: valid/ready channels of the Halton frame jitter unit
// One interface for the input transactions and one for the results.
// ============================================================================
interface hfj_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] step_seconds;
  logic signed [31:0] start_seconds;

  modport source (output valid, output operation, output step_seconds,
                  output start_seconds, input ready);
  modport sink   (input valid, input operation, input step_seconds,
                  input start_seconds, output ready);
endinterface

interface hfj_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] frame_number;
  logic        [31:0] elapsed_seconds;
  logic signed [23:0] jitter_x;
  logic signed [23:0] jitter_y;

  modport source (output valid, output frame_number, output elapsed_seconds,
                  output jitter_x, output jitter_y, input ready);
  modport sink   (input valid, input frame_number, input elapsed_seconds,
                  input jitter_x, input jitter_y, output ready);
endinterface

### rtl/halton_frame_jitter_unit.sv
// ============================================================================
// halton_frame_jitter_unit: per-frame Halton (2,3) subpixel jitter
// Keeps a saturating frame clock and a wrapping frame counter, and produces
// a jitter pair from the base-2 and base-3 radical inverses of the next
// frame index, scaled by a programmable strength.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------
//  in_ch    sink       valid / ready        operation, step_seconds, start_seconds
//  out_ch   source     valid / ready        frame_number, elapsed_seconds,
//                                           jitter_x, jitter_y
//  cfg      APB slave  psel/penable/pready  jitter_strength at byte address 0
//
//  An advance transaction extracts 21 ternary digits through a divide-by-three
//  reciprocal multiplier, runs a bit-serial restoring division by 3^21 for
//  the 24 fraction bits of the base-3 inverse, shares one multiplier for the
//  two scaled jitters, one after the other, and then moves the result into
//  the output register.
//  A reset transaction skips the arithmetic and goes straight to the hand-over.
//  One transaction is in flight at a time; the next is accepted once the
//  previous result has moved into the output register, which may still wait.
//  rst_n is synchronous; after it the strength is 1.0 and the timeline is zero.
//
module halton_frame_jitter_unit
  import hfj_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hfj_in_if.sink                in_ch,
  hfj_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Control state
  hfj_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      frame_r, frame_nxt;
  logic [31:0]      time_r, time_nxt;
  logic [15:0]      strength_r, strength_nxt;

  // Datapath registers
  logic [31:0]           n_r, n_nxt;        // remaining value during digit extraction
  logic [REV_W-1:0]      acc_r, acc_nxt;    // reversed ternary integer, then remainder
  logic [FRAC_BITS-1:0]  h2_r, h2_nxt;      // base-2 inverse
  logic [FRAC_BITS-1:0]  h3_r, h3_nxt;      // base-3 inverse, built a bit per cycle
  logic signed [23:0]    jx_r, jx_nxt;
  logic signed [23:0]    jy_r, jy_nxt;
  logic [31:0]           out_frame_r, out_frame_nxt;
  logic [31:0]           out_time_r, out_time_nxt;
  logic signed [23:0]    out_jx_r, out_jx_nxt;
  logic signed [23:0]    out_jy_r, out_jy_nxt;

  // Combinational helpers
  logic                  in_fire;
  logic                  cfg_wr;
  logic [31:0]           step_add;
  logic [32:0]           time_sum;
  logic [31:0]           k_val;
  logic [63:0]           div3_prod;
  logic [31:0]           div3_quot;
  logic [1:0]            digit;
  logic [REV_W-1:0]      acc_times3;
  logic [REV_W:0]        rem_shift;
  logic                  rem_ge;
  logic [FRAC_BITS-1:0]  scale_in;
  logic signed [24:0]    scale_dev;
  logic signed [16:0]    scale_gain;
  logic signed [41:0]    scale_prod;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Configuration port: single register, never inserts wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STRENGTH);
  assign prdata = (paddr[2] == REG_STRENGTH) ? {16'd0, strength_r} : '0;

  // Divide by three through the reciprocal; the digit is the 2-bit remainder
  assign div3_prod = 64'(n_r) * 64'(RECIP3);
  assign div3_quot = {1'b0, div3_prod[63:33]};
  assign digit     = n_r[1:0] - (div3_quot[1:0] + {div3_quot[0], 1'b0});

  // Horner step of the reversed ternary integer
  assign acc_times3 = {acc_r[REV_W-2:0], 1'b0} + acc_r + REV_W'(digit);

  // Restoring division step by 3^21
  assign rem_shift = {acc_r, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, TERN_SPAN});

  // Shared scaling multiplier: (h - 0.5) * strength, floored to Q8.16
  assign scale_in   = (state_r == ST_SCALE_X) ? h2_r : h3_r;
  assign scale_dev  = $signed({1'b0, scale_in}) - $signed({1'b0, HALF_Q24});
  assign scale_gain = $signed({1'b0, strength_r});
  assign scale_prod = scale_dev * scale_gain;

  // Time step and next frame index
  assign step_add = in_ch.step_seconds[31] ? 32'd0 : in_ch.step_seconds;
  assign time_sum = {1'b0, time_r} + {1'b0, step_add};
  assign k_val    = frame_r + 32'd2;

  // Sequencer and datapath next values
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    frame_nxt     = frame_r;
    time_nxt      = time_r;
    strength_nxt  = strength_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    h2_nxt        = h2_r;
    h3_nxt        = h3_r;
    jx_nxt        = jx_r;
    jy_nxt        = jy_r;
    out_frame_nxt = out_frame_r;
    out_time_nxt  = out_time_r;
    out_jx_nxt    = out_jx_r;
    out_jy_nxt    = out_jy_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (cfg_wr) begin
      strength_nxt = pwdata[15:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.operation == OP_RESET) begin
            time_nxt  = in_ch.start_seconds[31] ? 32'd0 : in_ch.start_seconds;
            frame_nxt = 32'd0;
            jx_nxt    = '0;
            jy_nxt    = '0;
            state_nxt = ST_DONE;
          end else begin
            time_nxt  = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
            frame_nxt = frame_r + 32'd1;
            n_nxt     = k_val;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            // Base-2 inverse is the low 24 bits of k in reversed order
            for (int j = 0; j < FRAC_BITS; j++) begin
              h2_nxt[FRAC_BITS-1-j] = k_val[j];
            end
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        n_nxt   = div3_quot;
        acc_nxt = acc_times3;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TERNARY_DIGITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        acc_nxt = rem_ge ? REV_W'(rem_shift - {1'b0, TERN_SPAN}) : REV_W'(rem_shift);
        h3_nxt  = {h3_r[FRAC_BITS-2:0], rem_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE_X;
        end
      end
      ST_SCALE_X: begin
        jx_nxt    = scale_prod[39:16];
        state_nxt = ST_SCALE_Y;
      end
      ST_SCALE_Y: begin
        jy_nxt    = scale_prod[39:16];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_frame_nxt = frame_r;
          out_time_nxt  = time_r;
          out_jx_nxt    = jx_r;
          out_jy_nxt    = jy_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      frame_r     <= '0;
      time_r      <= '0;
      strength_r  <= STRENGTH_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      frame_r     <= frame_nxt;
      time_r      <= time_nxt;
      strength_r  <= strength_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    acc_r       <= acc_nxt;
    h2_r        <= h2_nxt;
    h3_r        <= h3_nxt;
    jx_r        <= jx_nxt;
    jy_r        <= jy_nxt;
    out_frame_r <= out_frame_nxt;
    out_time_r  <= out_time_nxt;
    out_jx_r    <= out_jx_nxt;
    out_jy_r    <= out_jy_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_number    = out_frame_r;
  assign out_ch.elapsed_seconds = out_time_r;
  assign out_ch.jitter_x        = out_jx_r;
  assign out_ch.jitter_y        = out_jy_r;

endmodule

### rtl/hfj_checker.sv
// ============================================================================
// hfj_checker: port-level checks for the Halton frame jitter unit
// Watches the input and result channels over time; attached by bind.
// ============================================================================
module hfj_checker
  import hfj_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [31:0] out_frame,
  input logic        [31:0] out_time,
  input logic signed [23:0] out_jx,
  input logic signed [23:0] out_jy
);

  // Only one transaction is processed at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // A result that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_frame) &&
      $stable(out_time) && $stable(out_jx) && $stable(out_jy)))
    else $error("stalled result changed");

  // When the next frame index wraps to zero both inverses are zero
  a_wrap_jitter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_frame == 32'hFFFF_FFFF)) |-> (out_jx == out_jy))
    else $error("jitter pair differs at frame index wrap");

  // Reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not empty after reset");

endmodule

bind halton_frame_jitter_unit hfj_checker u_hfj_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_frame (out_ch.frame_number),
  .out_time  (out_ch.elapsed_seconds),
  .out_jx    (out_ch.jitter_x),
  .out_jy    (out_ch.jitter_y)
);
